### sv/cgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgf_pkg
// Shared types, constants and the fill table of the column gap fill unit.
// ----------------------------------------------------------------------------
package cgf_pkg;

   localparam int VALUE_W = 16;
   localparam int LIMIT_W = 5;
   localparam int COUNT_W = 6;
   localparam int DIST_W  = 6;
   localparam int SQ_W    = 11;
   localparam int M_W     = 3;
   localparam int MAX_RES = 31;
   localparam logic [LIMIT_W-1:0] RES_RESET = 5'd2;
   localparam logic [VALUE_W-1:0] EMPTY_Q   = 16'hFF00;

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_HIT  = 2'd1,
      PH_GAP  = 2'd2,
      PH_PASS = 2'd3
   } phase_type;

   // One command: count leading voxels (filled or empty), then the final voxel.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               fill;
      logic [LIMIT_W-1:0] limit;
      logic [VALUE_W-1:0] value;
      logic               cend;
   } cmd_type;

   // round(256 * e^-m) in Q7.8
   function automatic logic [VALUE_W-1:0] gauss_q(input logic [M_W-1:0] m);
      logic [VALUE_W-1:0] g;
      begin
         unique case (m)
            3'd0: g = 16'd256;
            3'd1: g = 16'd94;
            3'd2: g = 16'd35;
            3'd3: g = 16'd13;
            3'd4: g = 16'd5;
            3'd5: g = 16'd2;
            3'd6: g = 16'd1;
            default: g = 16'd0;
         endcase
         return g;
      end
   endfunction

endpackage

### sv/cgf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgf_front
// Accepts voxels, tracks the first gap of a column and issues output commands.
// ----------------------------------------------------------------------------
module cgf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [cgf_pkg::VALUE_W-1:0] req_voxel_value,
   input  logic                           req_column_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cgf_pkg::LIMIT_W-1:0]    csr_gap_limit,
   output logic                           push_valid,
   input  logic                           push_ready,
   output cgf_pkg::cmd_type               push_cmd
);

   cgf_pkg::phase_type            phase_ff, phase_in;
   logic [cgf_pkg::COUNT_W-1:0]   gap_ff, gap_in;
   logic [cgf_pkg::LIMIT_W-1:0]   res_ff;
   logic [cgf_pkg::LIMIT_W-1:0]   limit;
   logic                          accept;
   logic                          empty;
   logic [cgf_pkg::COUNT_W-1:0]   held;
   logic [cgf_pkg::COUNT_W-1:0]   cnt;
   logic                          flush;
   logic                          emit;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign empty     = req_voxel_value == cgf_pkg::EMPTY_Q;

   assign limit = ({1'b0, res_ff} < cgf_pkg::COUNT_W'(cgf_pkg::MAX_RES)) ? res_ff
                : cgf_pkg::LIMIT_W'(cgf_pkg::MAX_RES);

   assign held  = (phase_ff == cgf_pkg::PH_GAP) ? gap_ff : '0;
   assign cnt   = held + cgf_pkg::COUNT_W'(1);
   assign flush = (cnt > {1'b0, limit}) || req_column_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cgf_pkg::PH_SEEK;
         gap_ff   <= '0;
         res_ff   <= cgf_pkg::RES_RESET;
      end else begin
         phase_ff <= phase_in;
         gap_ff   <= gap_in;
         if (csr_valid && csr_ready) begin
            res_ff <= csr_gap_limit;
         end
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      gap_in   = gap_ff;
      if (accept) begin
         unique case (phase_ff)
            cgf_pkg::PH_SEEK: if (!empty) phase_in = cgf_pkg::PH_HIT;
            cgf_pkg::PH_PASS: phase_in = cgf_pkg::PH_PASS;
            cgf_pkg::PH_HIT, cgf_pkg::PH_GAP: begin
               if (empty) begin
                  if (flush) begin
                     phase_in = cgf_pkg::PH_PASS;
                     gap_in   = '0;
                  end else begin
                     phase_in = cgf_pkg::PH_GAP;
                     gap_in   = cnt;
                  end
               end else if (phase_ff == cgf_pkg::PH_GAP) begin
                  phase_in = cgf_pkg::PH_PASS;
                  gap_in   = '0;
               end
            end
            default: phase_in = cgf_pkg::PH_SEEK;
         endcase
         if (req_column_end) begin
            phase_in = cgf_pkg::PH_SEEK;
            gap_in   = '0;
         end
      end
   end

   // command out
   always_comb begin
      emit           = 1'b1;
      push_cmd.count = '0;
      push_cmd.fill  = 1'b0;
      push_cmd.limit = limit;
      push_cmd.value = req_voxel_value;
      push_cmd.cend  = req_column_end;
      unique case (phase_ff)
         cgf_pkg::PH_SEEK, cgf_pkg::PH_PASS: emit = 1'b1;
         cgf_pkg::PH_HIT, cgf_pkg::PH_GAP: begin
            if (empty) begin
               // hold unless the run is too long or the column ends
               emit           = flush;
               push_cmd.count = held;
               push_cmd.value = cgf_pkg::EMPTY_Q;
            end else begin
               push_cmd.count = held;
               push_cmd.fill  = (held <= {1'b0, limit}) && (limit != '0);
            end
         end
         default: emit = 1'b1;
      endcase
   end

   assign push_valid = accept && emit;

endmodule

### sv/cgf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module cgf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cgf_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cgf_pkg::cmd_type pop_cmd
);

   cgf_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/cgf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgf_back
// Executes commands: sends the held gap voxels, then the closing voxel.
// ----------------------------------------------------------------------------
module cgf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  cgf_pkg::cmd_type                   pop_cmd,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cgf_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                               rsp_column_last_out,
   output logic                               rsp_run_last
);

   logic                          busy_ff, busy_in;
   cgf_pkg::cmd_type              cmd_ff;
   logic [cgf_pkg::COUNT_W-1:0]   left_ff;
   logic [cgf_pkg::DIST_W-1:0]    dist_ff;
   logic [cgf_pkg::SQ_W-1:0]      sq_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [cgf_pkg::VALUE_W-1:0]   out_value_ff;
   logic                          out_col_ff;
   logic                          out_last_ff;
   logic                          advance;
   logic                          final_step;
   logic                          load;
   logic [cgf_pkg::M_W-1:0]       m;
   logic [cgf_pkg::SQ_W-1:0]      thr;
   logic [cgf_pkg::VALUE_W-1:0]   gap_value;

   assign advance    = busy_ff && (!out_valid_ff || rsp_ready);
   assign final_step = advance && (left_ff == '0);
   assign pop_ready  = !busy_ff || final_step;
   assign load       = pop_valid && pop_ready;

   // m = min(7, floor(d*d / (4*limit))), found by comparing against multiples of 4*limit
   always_comb begin
      m   = '0;
      thr = '0;
      for (int k = 1; k < 8; k++) begin
         thr = cgf_pkg::SQ_W'({cmd_ff.limit, 2'b00}) * cgf_pkg::SQ_W'(k);
         m   = m + cgf_pkg::M_W'(sq_ff >= thr);
      end
      gap_value = cmd_ff.fill ? cgf_pkg::gauss_q(m) : cgf_pkg::EMPTY_Q;
   end

   always_comb begin
      busy_in = busy_ff;
      if (final_step) busy_in = 1'b0;
      if (load) busy_in = 1'b1;
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (advance) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (left_ff != '0) begin
            out_value_ff <= gap_value;
            out_col_ff   <= 1'b0;
            out_last_ff  <= 1'b0;
            left_ff      <= left_ff - cgf_pkg::COUNT_W'(1);
            dist_ff      <= dist_ff + cgf_pkg::DIST_W'(1);
            // (d+1)^2 = d^2 + 2d + 1
            sq_ff        <= sq_ff + cgf_pkg::SQ_W'({dist_ff, 1'b1});
         end else begin
            out_value_ff <= cmd_ff.value;
            out_col_ff   <= cmd_ff.cend;
            out_last_ff  <= 1'b1;
         end
      end
      if (load) begin
         cmd_ff  <= pop_cmd;
         left_ff <= pop_cmd.count;
         dist_ff <= cgf_pkg::DIST_W'(1);
         sq_ff   <= cgf_pkg::SQ_W'(1);
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_value_out       = out_value_ff;
   assign rsp_column_last_out = out_col_ff;
   assign rsp_run_last        = out_last_ff;

endmodule

### sv/column_gap_fill_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_gap_fill_unit
// Fills the first short gap of empty voxels in each column of voxels.
// ----------------------------------------------------------------------------
// Each accepted voxel yields exactly one output voxel, in input order. Voxels
// of the first gap after the first occupied voxel are held (no output) until
// the gap is closed, overruns the gap limit or the column ends; they then
// leave as a burst, one per cycle while the receiver is ready, ending with the
// voxel that settled the gap. The front takes one voxel per cycle while the
// two-entry command queue has room; the back emits one voxel per cycle while
// the receiver is ready; during a burst the front keeps accepting until the
// queue fills. A voxel that passes straight through is registered in the
// command queue, in the back's command register and in its output register.
// ----------------------------------------------------------------------------
module column_gap_fill_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cgf_pkg::VALUE_W-1:0] req_voxel_value,
   input  logic                               req_column_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cgf_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                               rsp_column_last_out,
   output logic                               rsp_run_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cgf_pkg::LIMIT_W-1:0]        csr_gap_limit
);

   logic             push_valid;
   logic             push_ready;
   cgf_pkg::cmd_type push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   cgf_pkg::cmd_type pop_cmd;

   cgf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_voxel_value (req_voxel_value),
      .req_column_end  (req_column_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_gap_limit   (csr_gap_limit),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   cgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   cgf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_cmd             (pop_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value_out       (rsp_value_out),
      .rsp_column_last_out (rsp_column_last_out),
      .rsp_run_last        (rsp_run_last)
   );

endmodule

### verif/column_gap_fill_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_gap_fill_unit_tb
// Self-checking bench for the column gap fill unit. A directed table covers
// field extremes, gap filling, overruns, columns that end inside a gap and a
// zero gap limit. Random columns follow under several gap limit settings.
// Every output voxel is compared with a cycle-free model of the fill rules.
// ----------------------------------------------------------------------------
module column_gap_fill_unit_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 48;
   localparam int NUM_PHASES  = 8;
   localparam int NUM_ROWS    = 30;

   // round(256 * e^-m) for m = 0..7
   localparam logic [cgf_pkg::VALUE_W-1:0] FILL_LEVEL [8] = '{
      16'd256, 16'd94, 16'd35, 16'd13, 16'd5, 16'd2, 16'd1, 16'd0
   };

   typedef enum logic {ROW_VOXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [cgf_pkg::VALUE_W-1:0] value;
      logic                        cend;
      logic                        known;
      logic [cgf_pkg::VALUE_W-1:0] known_value;
      logic                        known_last;
   } row_type;

   typedef struct {
      logic [cgf_pkg::VALUE_W-1:0] value;
      logic                        col_last;
      logic                        run_last;
   } filled_voxel_type;

   // Directed rows run with the gap limit at its reset value of 2 until the
   // first register row.
   localparam row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_VOXEL, 16'h7FFF,         1'b0, 1'b1, 16'h7FFF,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h8000,         1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b1, cgf_pkg::EMPTY_Q, 1'b0},
      '{ROW_VOXEL, 16'h0005,         1'b1, 1'b1, 16'h0005,         1'b1},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b1, cgf_pkg::EMPTY_Q, 1'b0},
      '{ROW_VOXEL, 16'hFF01,         1'b0, 1'b1, 16'hFF01,         1'b0},
      '{ROW_VOXEL, 16'h0000,         1'b0, 1'b1, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h0064,         1'b1, 1'b1, 16'h0064,         1'b1},
      '{ROW_VOXEL, 16'h0001,         1'b0, 1'b1, 16'h0001,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b1, 1'b1, cgf_pkg::EMPTY_Q, 1'b1},
      '{ROW_VOXEL, 16'h0100,         1'b0, 1'b1, 16'h0100,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'hFEFF,         1'b1, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'hFFFF,         1'b1, 1'b1, 16'hFFFF,         1'b1},
      '{ROW_CSR,   16'd0,            1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h0007,         1'b0, 1'b1, 16'h0007,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b1, cgf_pkg::EMPTY_Q, 1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b1, 1'b1, cgf_pkg::EMPTY_Q, 1'b1},
      '{ROW_CSR,   16'd31,           1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h0003,         1'b0, 1'b1, 16'h0003,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, cgf_pkg::EMPTY_Q, 1'b0, 1'b0, 16'h0000,         1'b0},
      // shrink the limit while two voxels are held
      '{ROW_CSR,   16'd1,            1'b0, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h0009,         1'b1, 1'b0, 16'h0000,         1'b0},
      '{ROW_VOXEL, 16'h0080,         1'b1, 1'b1, 16'h0080,         1'b1}
   };

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [cgf_pkg::VALUE_W-1:0] req_voxel_value;
   logic                               req_column_end;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [cgf_pkg::VALUE_W-1:0] rsp_value_out;
   logic                               rsp_column_last_out;
   logic                               rsp_run_last;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [cgf_pkg::LIMIT_W-1:0]        csr_gap_limit;

   // typed expectation that travels with the item on the input channel
   logic                               req_known;
   logic [cgf_pkg::VALUE_W-1:0]        req_known_value;
   logic                               req_known_last;

   // column model state
   cgf_pkg::phase_type                 col_phase = cgf_pkg::PH_SEEK;
   logic [cgf_pkg::COUNT_W-1:0]        held_count = '0;
   logic [cgf_pkg::LIMIT_W-1:0]        gap_limit_q = cgf_pkg::RES_RESET;

   filled_voxel_type                   expected_voxels [$];
   int                                 mismatch_count = 0;
   int                                 items_sent = 0;
   int                                 burst_left = 0;
   int                                 idle_cycles = 0;
   logic                               hold_request = 1'b0;

   column_gap_fill_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_voxel_value     (req_voxel_value),
      .req_column_end      (req_column_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value_out       (rsp_value_out),
      .rsp_column_last_out (rsp_column_last_out),
      .rsp_run_last        (rsp_run_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_gap_limit       (csr_gap_limit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void queue_voxel(input logic [cgf_pkg::VALUE_W-1:0] value,
                                       input logic col_last, input logic run_last);
      filled_voxel_type fv;
      fv.value    = value;
      fv.col_last = col_last;
      fv.run_last = run_last;
      expected_voxels.insert(expected_voxels.size(), fv);
   endfunction

   // Advance the column state by one voxel and queue the voxels it releases.
   function automatic void advance_column(input logic [cgf_pkg::VALUE_W-1:0] v,
                                          input logic ce);
      logic empty;
      logic do_fill;
      int   lim;
      int   cnt;
      int   m;
      empty = (v == cgf_pkg::EMPTY_Q);
      lim   = (int'(gap_limit_q) < cgf_pkg::MAX_RES) ? int'(gap_limit_q)
                                                     : cgf_pkg::MAX_RES;
      if (col_phase == cgf_pkg::PH_SEEK || col_phase == cgf_pkg::PH_PASS) begin
         if (col_phase == cgf_pkg::PH_SEEK && !empty)
            col_phase = cgf_pkg::PH_HIT;
         queue_voxel(v, ce, 1'b1);
      end else if (empty) begin
         cnt = ((col_phase == cgf_pkg::PH_GAP) ? int'(held_count) : 0) + 1;
         if (cnt > lim || ce) begin
            for (int i = 1; i <= cnt; i++)
               queue_voxel(cgf_pkg::EMPTY_Q, (i == cnt) ? ce : 1'b0, i == cnt);
            col_phase  = cgf_pkg::PH_PASS;
            held_count = '0;
         end else begin
            col_phase  = cgf_pkg::PH_GAP;
            held_count = cgf_pkg::COUNT_W'(cnt);
         end
      end else if (col_phase == cgf_pkg::PH_HIT) begin
         queue_voxel(v, ce, 1'b1);
      end else begin
         do_fill = (int'(held_count) <= lim) && (lim != 0);
         for (int i = 1; i <= int'(held_count); i++) begin
            if (do_fill) begin
               m = (i * i) / (4 * lim);
               queue_voxel((m < 8) ? FILL_LEVEL[m] : '0, 1'b0, 1'b0);
            end else begin
               queue_voxel(cgf_pkg::EMPTY_Q, 1'b0, 1'b0);
            end
         end
         queue_voxel(v, ce, 1'b1);
         col_phase  = cgf_pkg::PH_PASS;
         held_count = '0;
      end
      if (ce) begin
         col_phase  = cgf_pkg::PH_SEEK;
         held_count = '0;
      end
   endfunction

   // Track accepted items and check accepted output voxels.
   always @(posedge clock) begin
      int               base_n;
      filled_voxel_type want;
      if (reset) begin
         col_phase   = cgf_pkg::PH_SEEK;
         held_count  = '0;
         gap_limit_q = cgf_pkg::RES_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_voxels.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected output voxel: expected none, actual %h/%b/%b",
                        $time, rsp_value_out, rsp_column_last_out, rsp_run_last);
            end else begin
               want = expected_voxels.pop_front();
               if (rsp_value_out !== want.value) begin
                  mismatch_count++;
                  $display("%0t value_out: expected %h, actual %h",
                           $time, want.value, rsp_value_out);
               end
               if (rsp_column_last_out !== want.col_last) begin
                  mismatch_count++;
                  $display("%0t column_last_out: expected %b, actual %b",
                           $time, want.col_last, rsp_column_last_out);
               end
               if (rsp_run_last !== want.run_last) begin
                  mismatch_count++;
                  $display("%0t run_last: expected %b, actual %b",
                           $time, want.run_last, rsp_run_last);
               end
            end
         end
         if (csr_valid && csr_ready)
            gap_limit_q = csr_gap_limit;
         if (req_valid && req_ready) begin
            base_n = expected_voxels.size();
            advance_column(req_voxel_value, req_column_end);
            if (req_known) begin
               // replace the model's voxel with the one typed into the table
               while (expected_voxels.size() > base_n)
                  void'(expected_voxels.pop_back());
               queue_voxel(req_known_value, req_known_last, 1'b1);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("column_gap_fill_unit_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: one long hold on request, otherwise a stall pattern that steps
   // through always ready, two random patterns and a fixed on/off pattern.
   initial begin
      int   rx_cycle;
      logic held_off;
      rx_cycle  = 0;
      held_off  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rx_cycle++;
            case ((rx_cycle / 97) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 2) == 0);
               default: rsp_ready <= ((rx_cycle % 13) < 8);
            endcase
         end
      end
   end

   // Offer one item, in bursts with random gaps, and wait until it is taken.
   task automatic offer_voxel(input logic [cgf_pkg::VALUE_W-1:0] v, input logic ce,
                              input logic known = 1'b0,
                              input logic [cgf_pkg::VALUE_W-1:0] known_value = '0,
                              input logic known_last = 1'b0);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_voxel_value <= v;
      req_column_end  <= ce;
      req_known       <= known;
      req_known_value <= known_value;
      req_known_last  <= known_last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stop offering and wait until every expected voxel has left.
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_voxels.size() != 0);
   endtask

   task automatic write_gap_limit(input logic [cgf_pkg::LIMIT_W-1:0] value);
      drain_results();
      // held voxels produce nothing; let the pipeline settle
      repeat (8) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_gap_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [cgf_pkg::VALUE_W-1:0] rand_occupied();
      logic [cgf_pkg::VALUE_W-1:0] v;
      v = cgf_pkg::VALUE_W'($urandom);
      if (v == cgf_pkg::EMPTY_Q)
         v = v ^ 16'h0001;
      return v;
   endfunction

   function automatic logic [cgf_pkg::VALUE_W-1:0] rand_voxel();
      if ($urandom_range(0, 3) == 0)
         return cgf_pkg::EMPTY_Q;
      return cgf_pkg::VALUE_W'($urandom);
   endfunction

   // Mostly well formed columns: leading empties, occupied voxels, one gap
   // sized around the limit, then a closing voxel and a random tail.
   task automatic send_random_column(input int lim);
      int   count;
      int   gap;
      int   r;
      logic end_in_gap;
      if ($urandom_range(0, 9) == 0) begin
         count = $urandom_range(1, 12);
         for (int i = 0; i < count; i++)
            offer_voxel(rand_voxel(), i == count - 1);
         return;
      end
      count = $urandom_range(0, 2);
      for (int i = 0; i < count; i++)
         offer_voxel(cgf_pkg::EMPTY_Q, 1'b0);
      count = $urandom_range(1, 3);
      for (int i = 0; i < count; i++)
         offer_voxel(rand_occupied(), 1'b0);
      r = $urandom_range(0, 9);
      if (r < 6)
         gap = $urandom_range(1, (lim > 0) ? lim : 1);
      else if (r < 8)
         gap = lim + 1;
      else
         gap = $urandom_range(0, lim + 3);
      end_in_gap = (gap > 0) && ($urandom_range(0, 4) == 0);
      for (int i = 0; i < gap; i++)
         offer_voxel(cgf_pkg::EMPTY_Q, end_in_gap && (i == gap - 1));
      if (end_in_gap)
         return;
      count = $urandom_range(0, 4);
      offer_voxel(rand_occupied(), count == 0);
      for (int i = 0; i < count; i++)
         offer_voxel(rand_voxel(), i == count - 1);
   endtask

   initial begin
      logic [cgf_pkg::LIMIT_W-1:0] res;
      int                          phase_start;
      int                          columns;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_voxel_value = '0;
      req_column_end  = 1'b0;
      req_known       = 1'b0;
      req_known_value = '0;
      req_known_last  = 1'b0;
      csr_valid       = 1'b0;
      csr_gap_limit   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR)
            write_gap_limit(DIRECTED_ROWS[i].value[cgf_pkg::LIMIT_W-1:0]);
         else
            offer_voxel(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].cend,
                        DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].known_value,
                        DIRECTED_ROWS[i].known_last);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0, 5: res = 5'd31;
            1:    res = 5'd1;
            2:    res = 5'd2;
            3:    res = 5'd0;
            default: res = cgf_pkg::LIMIT_W'($urandom_range(1, 8));
         endcase
         write_gap_limit(res);
         // stall the output while items keep coming so the block backs up
         if (p == 2)
            hold_request = 1'b1;
         phase_start = items_sent;
         columns     = 0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_random_column(int'(res));
            columns++;
            if (p == 4 && columns == 2)
               drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("column_gap_fill_unit_tb: PASS");
      else
         $display("column_gap_fill_unit_tb: FAIL");
      $finish;
   end

endmodule
